// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the line rasterizer RTL.
// Both sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression on every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed in line rasterizer");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen in line rasterizer");

`endif

// File: rtl/core/mlr_pkg.sv
// ---------------------------------------------------------------------------
// mlr_pkg
// Shared constants, zone codes and direction helpers for the midpoint
// line rasterizer.
// ---------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

    localparam int COORD_BITS_DEF = 12;

    // input item kinds, carried on s_axis_tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // zones, counterclockwise from +x
    localparam logic [2:0] ZONE_ENE = 3'd0;
    localparam logic [2:0] ZONE_NNE = 3'd1;
    localparam logic [2:0] ZONE_NNW = 3'd2;
    localparam logic [2:0] ZONE_WNW = 3'd3;
    localparam logic [2:0] ZONE_WSW = 3'd4;
    localparam logic [2:0] ZONE_SSW = 3'd5;
    localparam logic [2:0] ZONE_SSE = 3'd6;
    localparam logic [2:0] ZONE_ESE = 3'd7;

    // x-major zones are 0, 3, 4 and 7
    function automatic logic major_is_x(input logic [2:0] zone);
        major_is_x = (zone[1] == zone[0]);
    endfunction

    // major axis runs toward negative in zones 3..6
    function automatic logic major_neg(input logic [2:0] zone);
        major_neg = (zone == ZONE_WNW) || (zone == ZONE_WSW) ||
                    (zone == ZONE_SSW) || (zone == ZONE_SSE);
    endfunction

    // minor axis runs toward negative in zones 2, 4, 5 and 7
    function automatic logic minor_neg(input logic [2:0] zone);
        minor_neg = (zone == ZONE_NNW) || (zone == ZONE_WSW) ||
                    (zone == ZONE_SSW) || (zone == ZONE_ESE);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mlr_setup.sv
// ---------------------------------------------------------------------------
// mlr_setup
// Classifies the zone of a new line and derives the initial decision value,
// both increments, the major-axis end and the single-pixel flag.
// ---------------------------------------------------------------------------
`default_nettype none

module mlr_setup
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic signed [COORD_BITS-1:0] x_start,
    input  wire logic signed [COORD_BITS-1:0] y_start,
    input  wire logic signed [COORD_BITS-1:0] x_end,
    input  wire logic signed [COORD_BITS-1:0] y_end,
    output logic         [2:0]              zone,
    output logic signed  [COORD_BITS+2:0]   decision,
    output logic signed  [COORD_BITS+2:0]   inc_straight,
    output logic signed  [COORD_BITS+2:0]   inc_diagonal,
    output logic signed  [COORD_BITS-1:0]   major_end,
    output logic                            is_last
);

    localparam int DW = COORD_BITS + 1;
    localparam int W  = COORD_BITS + 3;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic        [DW-1:0] ax;
    logic        [DW-1:0] ay;
    logic                 x_major;
    logic signed [W-1:0]  dxw;
    logic signed [W-1:0]  dyw;
    logic signed [W-1:0]  dx2;
    logic signed [W-1:0]  dy2;
    logic signed [W-1:0]  sum2;
    logic signed [W-1:0]  diff2;

    assign dx = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
    assign dy = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
    assign ax = dx[DW-1] ? (-dx) : dx;
    assign ay = dy[DW-1] ? (-dy) : dy;
    assign x_major = (ax >= ay);

    assign dxw   = {{2{dx[DW-1]}}, dx};
    assign dyw   = {{2{dy[DW-1]}}, dy};
    assign dx2   = dxw + dxw;
    assign dy2   = dyw + dyw;
    assign sum2  = dy2 + dx2;
    assign diff2 = dy2 - dx2;

    always_comb
    begin
        if (!dx[DW-1] && !dy[DW-1])
        begin
            zone = x_major ? ZONE_ENE : ZONE_NNE;
        end
        else if (dx[DW-1] && !dy[DW-1])
        begin
            zone = x_major ? ZONE_WNW : ZONE_NNW;
        end
        else if (dx[DW-1])
        begin
            zone = x_major ? ZONE_WSW : ZONE_SSW;
        end
        else
        begin
            zone = x_major ? ZONE_ESE : ZONE_SSE;
        end
    end

    always_comb
    begin
        case (zone)
            ZONE_ENE:
            begin
                decision     = dy2 - dxw;
                inc_straight = dy2;
                inc_diagonal = diff2;
            end
            ZONE_NNE:
            begin
                decision     = dyw - dx2;
                inc_straight = -dx2;
                inc_diagonal = diff2;
            end
            ZONE_NNW:
            begin
                decision     = -dyw - dx2;
                inc_straight = -dx2;
                inc_diagonal = -sum2;
            end
            ZONE_WNW:
            begin
                decision     = -dy2 - dxw;
                inc_straight = -dy2;
                inc_diagonal = -sum2;
            end
            ZONE_WSW:
            begin
                decision     = dxw - dy2;
                inc_straight = -dy2;
                inc_diagonal = -diff2;
            end
            ZONE_SSW:
            begin
                decision     = dx2 - dyw;
                inc_straight = dx2;
                inc_diagonal = -diff2;
            end
            ZONE_SSE:
            begin
                decision     = dyw + dx2;
                inc_straight = dx2;
                inc_diagonal = sum2;
            end
            default:
            begin
                decision     = dy2 + dxw;
                inc_straight = dy2;
                inc_diagonal = sum2;
            end
        endcase
    end

    assign major_end = major_is_x(zone) ? x_end : y_end;
    assign is_last   = major_is_x(zone) ? (x_start == x_end) : (y_start == y_end);

endmodule

`default_nettype wire

// File: rtl/core/mlr_step.sv
// ---------------------------------------------------------------------------
// mlr_step
// One midpoint step: advance the major axis, take the minor move when the
// decision value calls for it, update the decision and flag the end pixel.
// ---------------------------------------------------------------------------
`default_nettype none

module mlr_step
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic        [2:0]            zone,
    input  wire logic signed [COORD_BITS-1:0] cur_x,
    input  wire logic signed [COORD_BITS-1:0] cur_y,
    input  wire logic signed [COORD_BITS+2:0] decision,
    input  wire logic signed [COORD_BITS+2:0] inc_straight,
    input  wire logic signed [COORD_BITS+2:0] inc_diagonal,
    input  wire logic signed [COORD_BITS-1:0] major_end,
    output logic signed      [COORD_BITS-1:0] next_x,
    output logic signed      [COORD_BITS-1:0] next_y,
    output logic signed      [COORD_BITS+2:0] next_decision,
    output logic                              is_last
);

    localparam logic [COORD_BITS-1:0] STEP_POS = {{(COORD_BITS-1){1'b0}}, 1'b1};
    localparam logic [COORD_BITS-1:0] STEP_NEG = {COORD_BITS{1'b1}};

    logic                  diag;
    logic [COORD_BITS-1:0] major_step;
    logic [COORD_BITS-1:0] minor_step;

    // even zones move diagonally on decision >= 0, odd zones on decision < 0
    assign diag = zone[0] ? decision[COORD_BITS+2] : !decision[COORD_BITS+2];

    assign major_step = major_neg(zone) ? STEP_NEG : STEP_POS;
    assign minor_step = !diag ? '0 : (minor_neg(zone) ? STEP_NEG : STEP_POS);

    always_comb
    begin
        if (major_is_x(zone))
        begin
            next_x = cur_x + major_step;
            next_y = cur_y + minor_step;
        end
        else
        begin
            next_x = cur_x + minor_step;
            next_y = cur_y + major_step;
        end
    end

    assign next_decision = decision + (diag ? inc_diagonal : inc_straight);
    assign is_last = major_is_x(zone) ? (next_x == major_end) : (next_y == major_end);

endmodule

`default_nettype wire

// File: rtl/core/midpoint_line_rasterizer_top.sv
// An input transfer passes the input register, then the output register.
// Throughput: one item per cycle while the output is not stalled; each step
// updates the line state as it moves from the input to the output register.
// Reset (rst_n low, asynchronous) clears both stage valids and the line
// state; a step with no line in progress returns pixel_valid = 0.
// ---------------------------------------------------------------------------
// midpoint_line_rasterizer_top
// Eight-zone midpoint line rasterizer with stream input and output ports.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module midpoint_line_rasterizer_top
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // x_start, y_start, x_end, y_end from bit 0 up, zero padded to bytes
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // op
    input  wire logic                                  s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // pixel_x, pixel_y, octant from bit 0 up, zero padded to bytes
    output logic [((2*COORD_BITS+3+7)/8)*8-1:0]        m_axis_tdata,
    // is_last
    output logic                                       m_axis_tlast,
    // pixel_valid
    output logic                                       m_axis_tuser
);

    localparam int C         = COORD_BITS;
    localparam int W         = COORD_BITS + 3;
    localparam int OUT_BITS  = 2*COORD_BITS + 3;
    localparam int OUT_TDW   = ((OUT_BITS+7)/8)*8;

    // input register
    logic                in_valid_reg;
    logic                in_op_reg;
    logic signed [C-1:0] in_xs_reg;
    logic signed [C-1:0] in_ys_reg;
    logic signed [C-1:0] in_xe_reg;
    logic signed [C-1:0] in_ye_reg;

    // line state
    logic signed [C-1:0] cur_x_reg,        cur_x_next;
    logic signed [C-1:0] cur_y_reg,        cur_y_next;
    logic signed [C-1:0] major_end_reg,    major_end_next;
    logic signed [W-1:0] decision_reg,     decision_next;
    logic signed [W-1:0] inc_straight_reg, inc_straight_next;
    logic signed [W-1:0] inc_diagonal_reg, inc_diagonal_next;
    logic        [2:0]   zone_reg,         zone_next;
    logic                active_reg,       active_next;

    // output register
    logic                out_valid_reg;
    logic signed [C-1:0] out_x_reg,   out_x_next;
    logic signed [C-1:0] out_y_reg,   out_y_next;
    logic        [2:0]   out_oct_reg, out_oct_next;
    logic                out_last_reg, out_last_next;
    logic                out_pv_reg,   out_pv_next;

    logic                advance;

    // setup results
    logic        [2:0]   su_zone;
    logic signed [W-1:0] su_decision;
    logic signed [W-1:0] su_inc_straight;
    logic signed [W-1:0] su_inc_diagonal;
    logic signed [C-1:0] su_major_end;
    logic                su_last;

    // step results
    logic signed [C-1:0] st_x;
    logic signed [C-1:0] st_y;
    logic signed [W-1:0] st_decision;
    logic                st_last;

    // move the held item into the output register when that slot frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    mlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .x_start      (in_xs_reg),
        .y_start      (in_ys_reg),
        .x_end        (in_xe_reg),
        .y_end        (in_ye_reg),
        .zone         (su_zone),
        .decision     (su_decision),
        .inc_straight (su_inc_straight),
        .inc_diagonal (su_inc_diagonal),
        .major_end    (su_major_end),
        .is_last      (su_last)
    );

    mlr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .zone          (zone_reg),
        .cur_x         (cur_x_reg),
        .cur_y         (cur_y_reg),
        .decision      (decision_reg),
        .inc_straight  (inc_straight_reg),
        .inc_diagonal  (inc_diagonal_reg),
        .major_end     (major_end_reg),
        .next_x        (st_x),
        .next_y        (st_y),
        .next_decision (st_decision),
        .is_last       (st_last)
    );

    always_comb
    begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        major_end_next    = major_end_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        zone_next         = zone_reg;
        active_next       = active_reg;
        out_x_next        = '0;
        out_y_next        = '0;
        out_oct_next      = '0;
        out_last_next     = 1'b0;
        out_pv_next       = 1'b0;
        if (in_op_reg == OP_START)
        begin
            // drop any line in progress and load the new one
            cur_x_next        = in_xs_reg;
            cur_y_next        = in_ys_reg;
            major_end_next    = su_major_end;
            decision_next     = su_decision;
            inc_straight_next = su_inc_straight;
            inc_diagonal_next = su_inc_diagonal;
            zone_next         = su_zone;
            active_next       = !su_last;
            out_x_next        = in_xs_reg;
            out_y_next        = in_ys_reg;
            out_oct_next      = su_zone;
            out_last_next     = su_last;
            out_pv_next       = 1'b1;
        end
        else if (active_reg)
        begin
            cur_x_next    = st_x;
            cur_y_next    = st_y;
            decision_next = st_decision;
            active_next   = !st_last;
            out_x_next    = st_x;
            out_y_next    = st_y;
            out_oct_next  = zone_reg;
            out_last_next = st_last;
            out_pv_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg <= s_axis_tuser;
            in_xs_reg <= s_axis_tdata[C-1:0];
            in_ys_reg <= s_axis_tdata[2*C-1:C];
            in_xe_reg <= s_axis_tdata[3*C-1:2*C];
            in_ye_reg <= s_axis_tdata[4*C-1:3*C];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            major_end_reg    <= '0;
            decision_reg     <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            zone_reg         <= '0;
            active_reg       <= 1'b0;
        end
        else if (advance)
        begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            major_end_reg    <= major_end_next;
            decision_reg     <= decision_next;
            inc_straight_reg <= inc_straight_next;
            inc_diagonal_reg <= inc_diagonal_next;
            zone_reg         <= zone_next;
            active_reg       <= active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
            out_oct_reg  <= out_oct_next;
            out_last_reg <= out_last_next;
            out_pv_reg   <= out_pv_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDW-OUT_BITS){1'b0}}, out_oct_reg, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_pv_reg;

    // an empty step carries all-zero fields
    `ASSERT_CLK(a_empty_step_zero,
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    // a line in progress has not yet reached its end point
    `ASSERT_CLK(a_active_not_at_end,
        active_reg |-> ((major_is_x(zone_reg) ? cur_x_reg : cur_y_reg) != major_end_reg))
    // emitting the end pixel closes the line
    `ASSERT_CLK(a_last_closes_line,
        (advance && out_last_next) |=> !active_reg)
    // input side stalls only behind a stalled output
    `ASSERT_NEVER(a_stall_cause,
        !s_axis_tready && !(out_valid_reg && !m_axis_tready))

endmodule

`default_nettype wire

// File: dv/midpoint_line_rasterizer_top_tb.sv
// ---------------------------------------------------------------------------
// midpoint_line_rasterizer_top_tb
// Drives start and step items into the eight-zone line rasterizer and checks
// every pixel against a midpoint predictor that tracks the line state. Directed
// lines cover every zone, ties, zero length, extremes and steps past the end;
// random lines follow, with random idling on both stream ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module midpoint_line_rasterizer_top_tb;
    import mlr_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int CMAX = (1 << (CB - 1)) - 1;
    localparam int CMIN = -(1 << (CB - 1));
    localparam int NUM_ITEMS = 1350;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic [2:0]    oct;
        logic          last;
        logic          valid;
    } pixel_t;

    class pixel_scoreboard;
        pixel_t     expected_pixels[$];
        int         pos_x, pos_y, stop_coord;
        int         err_term, step_s, step_d;
        logic [2:0] cur_zone;
        bit         running;
        int         errors, checked, starts, steps;
        int         zone_hits[8];

        function new();
            pos_x = 0; pos_y = 0; stop_coord = 0;
            err_term = 0; step_s = 0; step_d = 0;
            cur_zone = ZONE_ENE;
            running = 0;
            errors = 0; checked = 0; starts = 0; steps = 0;
            foreach (zone_hits[i]) zone_hits[i] = 0;
        endfunction

        function bit x_major(logic [2:0] z);
            return (z == ZONE_ENE) || (z == ZONE_WNW) || (z == ZONE_WSW) || (z == ZONE_ESE);
        endfunction

        function bit reached_end();
            return (x_major(cur_zone) ? pos_x : pos_y) == stop_coord;
        endfunction

        function void push_pixel(bit last);
            pixel_t p;
            p.px = pos_x[CB-1:0];
            p.py = pos_y[CB-1:0];
            p.oct = cur_zone;
            p.last = last;
            p.valid = 1'b1;
            running = !last;
            expected_pixels.push_back(p);
        endfunction

        function void start_line(int x0, int y0, int x1, int y1);
            int dx, dy, ax, ay;
            bit xmaj;
            dx = x1 - x0;
            dy = y1 - y0;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            xmaj = ax >= ay;
            if (dx >= 0 && dy >= 0) cur_zone = xmaj ? ZONE_ENE : ZONE_NNE;
            else if (dx < 0 && dy >= 0) cur_zone = xmaj ? ZONE_WNW : ZONE_NNW;
            else if (dx < 0) cur_zone = xmaj ? ZONE_WSW : ZONE_SSW;
            else cur_zone = xmaj ? ZONE_ESE : ZONE_SSE;
            case (cur_zone)
                ZONE_ENE: begin err_term = 2*dy - dx;  step_s = 2*dy;  step_d = 2*(dy - dx);  end
                ZONE_NNE: begin err_term = dy - 2*dx;  step_s = -2*dx; step_d = 2*(dy - dx);  end
                ZONE_NNW: begin err_term = -dy - 2*dx; step_s = -2*dx; step_d = -2*(dy + dx); end
                ZONE_WNW: begin err_term = -2*dy - dx; step_s = -2*dy; step_d = -2*(dy + dx); end
                ZONE_WSW: begin err_term = -2*dy + dx; step_s = -2*dy; step_d = 2*(dx - dy);  end
                ZONE_SSW: begin err_term = -dy + 2*dx; step_s = 2*dx;  step_d = 2*(dx - dy);  end
                ZONE_SSE: begin err_term = dy + 2*dx;  step_s = 2*dx;  step_d = 2*(dy + dx);  end
                default:  begin err_term = 2*dy + dx;  step_s = 2*dy;  step_d = 2*(dy + dx);  end
            endcase
            pos_x = x0;
            pos_y = y0;
            stop_coord = x_major(cur_zone) ? x1 : y1;
            starts++;
            zone_hits[cur_zone]++;
            push_pixel(reached_end());
        endfunction

        function void advance();
            int  mj, mn;
            bit  diag;
            pixel_t idle_px;
            steps++;
            if (!running) begin
                idle_px.px = '0; idle_px.py = '0; idle_px.oct = '0;
                idle_px.last = 1'b0; idle_px.valid = 1'b0;
                expected_pixels.push_back(idle_px);
                return;
            end
            case (cur_zone)
                ZONE_ENE: begin mj =  1; mn =  1; end
                ZONE_NNE: begin mj =  1; mn =  1; end
                ZONE_NNW: begin mj =  1; mn = -1; end
                ZONE_WNW: begin mj = -1; mn =  1; end
                ZONE_WSW: begin mj = -1; mn = -1; end
                ZONE_SSW: begin mj = -1; mn = -1; end
                ZONE_SSE: begin mj = -1; mn =  1; end
                default:  begin mj =  1; mn = -1; end
            endcase
            diag = cur_zone[0] ? (err_term < 0) : (err_term >= 0);
            if (x_major(cur_zone)) begin
                pos_x += mj;
                if (diag) pos_y += mn;
            end
            else begin
                pos_y += mj;
                if (diag) pos_x += mn;
            end
            err_term += diag ? step_d : step_s;
            push_pixel(reached_end());
        endfunction

        function void note_input(logic op, int x0, int y0, int x1, int y1);
            if (op == OP_START) start_line(x0, y0, x1, y1);
            else advance();
        endfunction

        function void check_result(logic [CB-1:0] px, logic [CB-1:0] py, logic [2:0] oct,
                                   logic last, logic valid);
            pixel_t e;
            if (expected_pixels.size() == 0) begin
                $error("pixel transfer with no pending expectation");
                errors++;
                return;
            end
            e = expected_pixels.pop_front();
            checked++;
            if (px !== e.px) begin
                $error("pixel_x mismatch: expected %0d, actual %0d", $signed(e.px), $signed(px));
                errors++;
            end
            if (py !== e.py) begin
                $error("pixel_y mismatch: expected %0d, actual %0d", $signed(e.py), $signed(py));
                errors++;
            end
            if (oct !== e.oct) begin
                $error("octant mismatch: expected %0d, actual %0d", e.oct, oct);
                errors++;
            end
            if (last !== e.last) begin
                $error("is_last mismatch: expected %0b, actual %0b", e.last, last);
                errors++;
            end
            if (valid !== e.valid) begin
                $error("pixel_valid mismatch: expected %0b, actual %0b", e.valid, valid);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    pixel_scoreboard sb;
    bit quiet;
    int sent;
    int stall_cycles;

    midpoint_line_rasterizer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Entered and left at a falling edge.
    task automatic send_item(input logic op, input int x0, input int y0,
                             input int x1, input int y1);
        while (!quiet && $urandom_range(0, 99) < 19) begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {y1[CB-1:0], x1[CB-1:0], y0[CB-1:0], x0[CB-1:0]};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(op, x0, y0, x1, y1);
        sent++;
        @(negedge clk);
    endtask

    task automatic start_line(input int x0, input int y0, input int x1, input int y1);
        send_item(OP_START, x0, y0, x1, y1);
    endtask

    task automatic step_line(input int n);
        repeat (n) send_item(OP_STEP, 0, 0, 0, 0);
    endtask

    function automatic int full_range();
        return int'($urandom_range(0, CMAX - CMIN)) + CMIN;
    endfunction

    // Keep the far endpoint on the grid by mirroring the offset if needed.
    function automatic int offset_point(int base, int d);
        int v;
        v = base + d;
        if (v > CMAX || v < CMIN) v = base - d;
        return v;
    endfunction

    function automatic int rand_offset(int span);
        int d;
        d = $urandom_range(0, span);
        return $urandom_range(0, 1) ? -d : d;
    endfunction

    // Output side: random stalls, sampled at the rising edge.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            m_axis_tready = quiet || ($urandom_range(0, 99) >= 19);
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[CB-1:0], m_axis_tdata[2*CB-1:CB],
                                m_axis_tdata[2*CB+2:2*CB], m_axis_tlast, m_axis_tuser);
        end
    end

    // Watchdog: count cycles with no transfer on either port.
    initial begin
        stall_cycles = 0;
        forever begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int x0, y0, x1, y1, major, kind, n;
        bit drained;
        sb = new();
        quiet = 1'b0;
        sent = 0;
        drained = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_START;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: idle step, zero length, ties in all x-major zones
        step_line(1);
        start_line(5, 5, 5, 5);
        step_line(1);
        start_line(0, 0, 3, 3);
        step_line(4);
        start_line(0, 0, -2, 2);
        step_line(2);
        start_line(0, 0, -2, -2);
        start_line(0, 0, 2, -2);
        step_line(1);
        // y-major zones, each dropped by the next start
        start_line(0, 0, 1, 3);
        step_line(1);
        start_line(0, 0, -1, 3);
        start_line(0, 0, -1, -3);
        step_line(1);
        start_line(0, 0, 1, -3);
        // grid extremes
        start_line(CMIN, CMIN, CMAX, CMAX);
        step_line(2);
        start_line(CMAX, CMIN, CMIN, CMAX);
        step_line(1);
        start_line(CMIN, CMAX, CMAX, CMIN);

        while (sent < NUM_ITEMS) begin
            quiet = (sent >= 300 && sent < 550);
            if (!drained && sent >= 750) begin
                s_axis_tvalid = 1'b0;
                while (sb.pending() != 0) @(negedge clk);
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                x0 = full_range();
                y0 = full_range();
                x1 = offset_point(x0, rand_offset(24));
                if ($urandom_range(0, 9) == 0)
                    y1 = offset_point(y0, $urandom_range(0, 1) ? (x1 - x0) : (x0 - x1));
                else
                    y1 = offset_point(y0, rand_offset(24));
                major = (x1 > x0 ? x1 - x0 : x0 - x1);
                if ((y1 > y0 ? y1 - y0 : y0 - y1) > major)
                    major = (y1 > y0 ? y1 - y0 : y0 - y1);
                n = major + $urandom_range(0, 2);
                if ($urandom_range(0, 99) < 15) n = $urandom_range(0, major);
                start_line(x0, y0, x1, y1);
                step_line(n);
            end
            else if (kind < 93) begin
                start_line(full_range(), full_range(), full_range(), full_range());
                step_line($urandom_range(0, 30));
            end
            else begin
                step_line($urandom_range(1, 3));
            end
        end

        // drain, then leave room for any stray transfer
        s_axis_tvalid = 1'b0;
        quiet = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d line starts and %0d steps, %0d pixels checked",
                 sb.starts, sb.steps, sb.checked);
        $display("line starts per zone 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.zone_hits[0], sb.zone_hits[1], sb.zone_hits[2], sb.zone_hits[3],
                 sb.zone_hits[4], sb.zone_hits[5], sb.zone_hits[6], sb.zone_hits[7]);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
